>>> src/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
// No dependencies; every file but gsa_ram imports this package.
package gsa_pkg;

  // Request kinds carried on the input channel.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ALLOC  = 2'd0;
  localparam kind_t KIND_FREE   = 2'd1;
  localparam kind_t KIND_LOOKUP = 2'd2;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_OK               = 3'd0;
  localparam status_t ST_NOT_READY        = 3'd1;
  localparam status_t ST_POOL_FULL        = 3'd2;
  localparam status_t ST_SERIAL_EXHAUSTED = 3'd3;
  localparam status_t ST_STALE            = 3'd4;

  // Configuration register indexes.
  typedef logic [3:0] cfg_index_t;
  localparam cfg_index_t REG_HEAP_READY = 4'd0;
  localparam cfg_index_t REG_STRIDE     = 4'd1;
  localparam cfg_index_t REG_CPU_BASE   = 4'd2;
  localparam cfg_index_t REG_GPU_BASE   = 4'd3;

  localparam int STRIDE_W = 13;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;
  localparam logic [31:0] SERIAL_ALL_ONES = 32'hffff_ffff;

  // Configuration register set.
  typedef struct packed {
    logic                heap_ready;
    logic [STRIDE_W-1:0] stride;
    logic [63:0]         cpu_base;
    logic [63:0]         gpu_base;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [7:0]  given_index;
    logic [31:0] given_serial;
    logic [63:0] cpu_address;
    logic [63:0] gpu_address;
    logic [8:0]  live_count;
    logic [8:0]  peak_count;
  } result_t;

endpackage

>>> src/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/gsa_cfg.sv
// Configuration register file of the slot allocator.
// Depends on gsa_pkg for the register indexes and the cfg_t struct.
module gsa_cfg import gsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  cfg_index_t cfg_index,
  input  logic [63:0] cfg_data,
  output cfg_t       cfg
);

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_ready <= 1'b0;
      cfg.stride     <= STRIDE_RESET;
      cfg.cpu_base   <= '0;
      cfg.gpu_base   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEAP_READY: cfg.heap_ready <= cfg_data[0];
        REG_STRIDE:     cfg.stride     <= cfg_data[STRIDE_W-1:0];
        REG_CPU_BASE:   cfg.cpu_base   <= cfg_data;
        REG_GPU_BASE:   cfg.gpu_base   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/gsa_exec.sv
// Request execution of the slot allocator: pool counters and the decision logic.
// Depends on gsa_pkg; the slot table and free stack RAMs sit in the top level.
module gsa_exec import gsa_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  cfg_t                       cfg,
  input  kind_t                      kind,
  input  logic [$clog2(SLOTS)-1:0]   idx,
  input  logic                       idx_ok,
  input  logic [31:0]                serial,
  input  logic [$clog2(SLOTS)+STRIDE_W-1:0] off,
  input  logic [32:0]                tag_word,
  input  logic [$clog2(SLOTS)-1:0]   stk_slot,
  output result_t                    result,
  output logic                       tag_we,
  output logic [$clog2(SLOTS)-1:0]   tag_waddr,
  output logic [32:0]                tag_wdata,
  output logic                       stk_we,
  output logic [$clog2(SLOTS)-1:0]   stk_waddr,
  output logic [$clog2(SLOTS)-1:0]   stk_wdata,
  output logic [$clog2(SLOTS)-1:0]   stk_raddr_next
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  logic [CNT_W-1:0] free_depth, free_depth_next;
  logic [CNT_W-1:0] bump_ptr, bump_ptr_next;
  logic [31:0]      serial_ctr, serial_ctr_next;
  logic [CNT_W-1:0] live_total, live_total_next;
  logic [CNT_W-1:0] peak_total, peak_total_next;
  logic [CNT_W-1:0] depth_after;
  logic [IDX_W-1:0] alloc_slot;
  logic             handle_live;
  logic             got;
  logic             tag_we_c, stk_we_c;

  // A handle is live when the heap is ready and it is in range, nonzero, inside
  // the touched part of the pool, marked in use and carries the matching serial.
  assign handle_live = cfg.heap_ready && idx_ok && (serial != '0) &&
                       (CNT_W'(idx) < bump_ptr) && tag_word[32] &&
                       (tag_word[31:0] == serial);

  // Decision logic for one request.
  always_comb begin
    free_depth_next = free_depth;
    bump_ptr_next   = bump_ptr;
    serial_ctr_next = serial_ctr;
    live_total_next = live_total;
    peak_total_next = peak_total;
    alloc_slot      = stk_slot;
    got             = 1'b0;
    tag_we_c        = 1'b0;
    tag_waddr       = idx;
    tag_wdata       = {1'b0, tag_word[31:0]};
    stk_we_c        = 1'b0;
    stk_waddr       = IDX_W'(free_depth);
    stk_wdata       = idx;
    result          = '0;
    result.status   = ST_OK;

    case (kind)
      KIND_ALLOC: begin
        if (!cfg.heap_ready) begin
          result.status = ST_NOT_READY;
        end else if (serial_ctr == SERIAL_ALL_ONES) begin
          result.status = ST_SERIAL_EXHAUSTED;
        end else if (free_depth != '0) begin
          free_depth_next = free_depth - 1'b1;
          alloc_slot      = stk_slot;
          got             = 1'b1;
        end else if (bump_ptr < SLOTS_CNT) begin
          alloc_slot    = IDX_W'(bump_ptr);
          bump_ptr_next = bump_ptr + 1'b1;
          got           = 1'b1;
        end else begin
          result.status = ST_POOL_FULL;
        end
        if (got) begin
          serial_ctr_next     = serial_ctr + 1'b1;
          tag_we_c            = 1'b1;
          tag_waddr           = alloc_slot;
          tag_wdata           = {1'b1, serial_ctr_next};
          live_total_next     = live_total + 1'b1;
          if (live_total_next > peak_total) begin
            peak_total_next = live_total_next;
          end
          result.ok           = 1'b1;
          result.given_index  = 8'(alloc_slot);
          result.given_serial = serial_ctr_next;
        end
      end
      KIND_FREE, KIND_LOOKUP: begin
        if (!cfg.heap_ready) begin
          result.status = ST_NOT_READY;
        end else if (!handle_live) begin
          result.status = ST_STALE;
        end else if (kind == KIND_FREE) begin
          tag_we_c = 1'b1;
          if (free_depth < SLOTS_CNT) begin
            stk_we_c        = 1'b1;
            free_depth_next = free_depth + 1'b1;
          end
          if (live_total != '0) begin
            live_total_next = live_total - 1'b1;
          end
          result.ok = 1'b1;
        end else begin
          result.cpu_address = cfg.cpu_base + 64'(off);
          result.gpu_address = cfg.gpu_base + 64'(off);
          result.ok          = 1'b1;
        end
      end
      default: begin
        result.status = ST_STALE;
      end
    endcase

    result.live_count = 9'(live_total_next);
    result.peak_count = 9'(peak_total_next);
  end

  assign tag_we = fire && tag_we_c;
  assign stk_we = fire && stk_we_c;

  // The next request reads the stack top as it stands after this one.
  assign depth_after    = fire ? free_depth_next : free_depth;
  assign stk_raddr_next = IDX_W'(depth_after - 1'b1);

  // Pool counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_depth <= '0;
      bump_ptr   <= '0;
      serial_ctr <= '0;
      live_total <= '0;
      peak_total <= '0;
    end else if (fire) begin
      free_depth <= free_depth_next;
      bump_ptr   <= bump_ptr_next;
      serial_ctr <= serial_ctr_next;
      live_total <= live_total_next;
      peak_total <= peak_total_next;
    end
  end

endmodule

>>> src/generational_slot_allocator.sv
// Generational slot allocator for a pool of SLOTS descriptor slots.
//
// Channels: a request word (kind, slot_index, slot_serial) on in_valid/in_ready,
// a result word on out_valid/out_ready, and a configuration write word
// (cfg_index, cfg_data) on cfg_valid/cfg_ready, which is always ready.
// The user must write configuration only with no request outstanding; unchecked.
//
// Timing: a request accepted into the request register is executed as soon as
// the result register is free or being taken, and its result word is then held
// in the result register until the receiver takes it.
// Throughput: one request per cycle while out_ready stays high. The slot table and free stack are read
// at accept and written at execution; a bypass from the previous write covers
// back-to-back requests on the same entry.
//
// Reset: the pool is empty and the configuration registers return to their
// defaults. The slot table needs no clearing pass, since only slots below the
// bump pointer are ever looked at.
//
// Stall: while out_ready is low the result word holds, one more request waits
// in the request register, and in_ready then drops until the result is taken.
module generational_slot_allocator import gsa_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] slot_index,
  input  logic [31:0] slot_serial,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [2:0]  status,
  output logic [7:0]  given_index,
  output logic [31:0] given_serial,
  output logic [63:0] cpu_address,
  output logic [63:0] gpu_address,
  output logic [8:0]  live_count,
  output logic [8:0]  peak_count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int OFF_W = IDX_W + STRIDE_W;
  localparam int TAG_W = 33;

  cfg_t    cfg;
  result_t result, result_q;

  logic             in_fire, exec_fire;
  logic             stage_valid;
  kind_t            stage_kind;
  logic [IDX_W-1:0] stage_idx;
  logic             stage_idx_ok;
  logic [31:0]      stage_serial;
  logic [OFF_W-1:0] stage_off;
  logic [IDX_W-1:0] stage_stk_raddr;

  logic             tag_we, stk_we;
  logic [IDX_W-1:0] tag_waddr, stk_waddr, stk_wdata, stk_raddr_next;
  logic [TAG_W-1:0] tag_wdata, tag_rdata, tag_word;
  logic [IDX_W-1:0] stk_rdata, stk_slot;

  logic             fwd_tag_we, fwd_stk_we;
  logic [IDX_W-1:0] fwd_tag_addr, fwd_stk_addr, fwd_stk_data;
  logic [TAG_W-1:0] fwd_tag_data;

  assign cfg_ready = 1'b1;

  gsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the request register drains whenever the result register frees.
  assign exec_fire = stage_valid && (!out_valid || out_ready);
  assign in_ready  = !stage_valid || exec_fire;
  assign in_fire   = in_valid && in_ready;

  // Request register; the address offset is multiplied here.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_fire) begin
      stage_valid <= 1'b1;
    end else if (exec_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_kind      <= kind;
      stage_idx       <= slot_index[IDX_W-1:0];
      stage_idx_ok    <= slot_index < 32'(SLOTS);
      stage_serial    <= slot_serial;
      stage_off       <= OFF_W'(slot_index[IDX_W-1:0]) * OFF_W'(cfg.stride);
      stage_stk_raddr <= stk_raddr_next;
    end
  end

  // Slot table: in-use flag above the 32-bit serial tag.
  gsa_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (in_fire),
    .raddr (slot_index[IDX_W-1:0]),
    .rdata (tag_rdata)
  );

  // LIFO stack of freed slot indexes.
  gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (in_fire),
    .raddr (stk_raddr_next),
    .rdata (stk_rdata)
  );

  // Bypass: remember a write that landed at the same edge as the next read.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_tag_we <= 1'b0;
      fwd_stk_we <= 1'b0;
    end else if (in_fire) begin
      fwd_tag_we <= tag_we;
      fwd_stk_we <= stk_we;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_tag_addr <= tag_waddr;
      fwd_tag_data <= tag_wdata;
      fwd_stk_addr <= stk_waddr;
      fwd_stk_data <= stk_wdata;
    end
  end

  assign tag_word = (fwd_tag_we && (fwd_tag_addr == stage_idx)) ? fwd_tag_data : tag_rdata;
  assign stk_slot = (fwd_stk_we && (fwd_stk_addr == stage_stk_raddr)) ? fwd_stk_data
                                                                     : stk_rdata;

  gsa_exec #(.SLOTS(SLOTS)) u_exec (
    .clk            (clk),
    .rst            (rst),
    .fire           (exec_fire),
    .cfg            (cfg),
    .kind           (stage_kind),
    .idx            (stage_idx),
    .idx_ok         (stage_idx_ok),
    .serial         (stage_serial),
    .off            (stage_off),
    .tag_word       (tag_word),
    .stk_slot       (stk_slot),
    .result         (result),
    .tag_we         (tag_we),
    .tag_waddr      (tag_waddr),
    .tag_wdata      (tag_wdata),
    .stk_we         (stk_we),
    .stk_waddr      (stk_waddr),
    .stk_wdata      (stk_wdata),
    .stk_raddr_next (stk_raddr_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result_q <= result;
    end
  end

  assign ok           = result_q.ok;
  assign status       = result_q.status;
  assign given_index  = result_q.given_index;
  assign given_serial = result_q.given_serial;
  assign cpu_address  = result_q.cpu_address;
  assign gpu_address  = result_q.gpu_address;
  assign live_count   = result_q.live_count;
  assign peak_count   = result_q.peak_count;

endmodule

>>> src/gsa_checker.sv
// Port-level checks for the generational slot allocator, bound to the top level.
// Depends on gsa_pkg for the status codes.
module gsa_checker import gsa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [2:0]  status,
  input logic [7:0]  given_index,
  input logic [31:0] given_serial,
  input logic [63:0] cpu_address
);

  logic [31:0] last_serial;

  // Serial of the most recent successful allocate word taken at the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_serial <= '0;
    end else if (out_valid && out_ready && (given_serial != '0)) begin
      last_serial <= given_serial;
    end
  end

  // No result word may appear right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // Success and status code agree, and a failed word hands out no slot.
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((ok == (status == ST_OK)) &&
                   (ok || ((given_serial == '0) && (given_index == '0)))))
    else $error("ok and status disagree");

  // Serials handed out strictly increase across the whole run.
  a_serial_rises: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && (given_serial != '0)) |-> (given_serial > last_serial))
    else $error("allocated serial did not increase");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(given_serial) && $stable(cpu_address)))
    else $error("result word changed while stalled");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);
